@@ design/slxfp_pkg.sv @@
// ---------------------------------------------------------------------------
// slxfp_pkg: shared types and constants of the start/length/XOR frame parser
// Holds the register codes, the reset values, the payload store geometry and
// the structs passed between the front end, the command queue and the back end.
// ---------------------------------------------------------------------------
package slxfp_pkg;

  // Payload store geometry: two banks of BUF_DEPTH bytes each.
  localparam int BUF_DEPTH   = 64;
  localparam int IDX_W       = 6;
  localparam int BANK_W      = 1;
  localparam int MEM_ADDR_W  = BANK_W + IDX_W;
  localparam int MEM_DEPTH   = 2 * BUF_DEPTH;
  localparam int RUN_W       = 7;

  // Command queue between front and back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_START_CODE      = 2'd0;
  localparam logic [1:0] CFG_EXPECTED_LENGTH = 2'd1;
  localparam logic [1:0] CFG_ACCEPT_LIMIT    = 2'd2;

  // Register reset values.
  localparam logic [7:0] START_CODE_RST      = 8'hAA;
  localparam logic [6:0] EXPECTED_LENGTH_RST = 7'd42;
  localparam logic [7:0] ACCEPT_LIMIT_RST    = 8'd128;

  typedef struct packed {
    logic [7:0] start_code;
    logic [6:0] expected_length;
    logic [7:0] accept_limit;
  } cfg_t;

  typedef struct packed {
    logic                  en;
    logic [MEM_ADDR_W-1:0] addr;
    logic [7:0]            data;
  } mem_wr_t;

  // One delivery job: which bank holds the payload and how many bytes to send.
  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [RUN_W-1:0]  count;
  } cmd_t;

endpackage

@@ design/start_length_xor_frame_parser_unit.sv @@
// ---------------------------------------------------------------------------
// start_length_xor_frame_parser_unit: serial frame parser, top level
// Finds start/length/payload/XOR-checksum frames in a byte stream and
// delivers the payload of every good frame as a marked run of bytes.
// ---------------------------------------------------------------------------
// Usage. The receive channel (rx_valid, rx_stall, rx_byte) takes one byte per
// item. The result channel (out_valid, out_stall, payload_byte, byte_position,
// last_byte) carries one payload byte per item, with last_byte set on the
// final byte of a frame. Bad frames produce no items at all. The config
// channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready and
// writes start_code, expected_length and accept_limit; other indexes are
// ignored. Write it only while the parser is quiet.
// Throughput: the front end accepts one byte every cycle while rx_stall is low.
// Payloads go into one of two store banks, and rx_stall rises only while two
// good frames are still waiting to be sent out; the job queue depth sets that
// limit. The back end sends one byte per cycle while out_stall is low.
// The first byte of a frame passes the job queue, the registered memory read
// and the output register after its checksum byte is accepted.
// Reset: the parser hunts for a start byte, the job queue is empty and the
// registers return to start code 0xAA, expected length 42, accept limit 128.
// A stalled receiver just holds the current result; delivery pauses and the
// input keeps flowing until both banks are taken.
// ---------------------------------------------------------------------------
module start_length_xor_frame_parser_unit (
  input  logic       clk,
  input  logic       rst,
  // Receive channel
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  // Result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] payload_byte,
  output logic [5:0] byte_position,
  output logic       last_byte,
  // Configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  slxfp_pkg::cfg_t    cfg;
  slxfp_pkg::mem_wr_t wr;
  slxfp_pkg::cmd_t    push_cmd;
  slxfp_pkg::cmd_t    head;
  logic               push, pop, not_empty, full;
  logic               rx_fire;

  // The register file never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_code      <= slxfp_pkg::START_CODE_RST;
      cfg.expected_length <= slxfp_pkg::EXPECTED_LENGTH_RST;
      cfg.accept_limit    <= slxfp_pkg::ACCEPT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        slxfp_pkg::CFG_START_CODE:      cfg.start_code      <= cfg_data;
        slxfp_pkg::CFG_EXPECTED_LENGTH: cfg.expected_length <= cfg_data[6:0];
        slxfp_pkg::CFG_ACCEPT_LIMIT:    cfg.accept_limit    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // With both banks holding frames that wait for delivery, the bank the
  // front end would write next is still in use, so the input is held off.
  assign rx_stall = full;
  assign rx_fire  = rx_valid && !rx_stall;

  slxfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .rx_fire  (rx_fire),
    .rx_byte  (rx_byte),
    .wr       (wr),
    .push     (push),
    .push_cmd (push_cmd)
  );

  slxfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  slxfp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .wr            (wr),
    .head          (head),
    .not_empty     (not_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_byte  (payload_byte),
    .byte_position (byte_position),
    .last_byte     (last_byte)
  );

endmodule

@@ design/slxfp_front.sv @@
// ---------------------------------------------------------------------------
// slxfp_front: frame hunting and checking front end
// Walks the start, length, payload and checksum phases, writes payload bytes
// into the free bank and queues a delivery job for every frame that passes.
// ---------------------------------------------------------------------------
module slxfp_front (
  input  logic                           clk,
  input  logic                           rst,
  input  slxfp_pkg::cfg_t                cfg,
  input  logic                           rx_fire,
  input  logic [7:0]                     rx_byte,
  output slxfp_pkg::mem_wr_t             wr,
  output logic                           push,
  output slxfp_pkg::cmd_t                push_cmd
);

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_CSUM = 4'b1000
  } phase_t;

  phase_t                             phase, phase_next;
  logic [7:0]                         frame_length, frame_length_next;
  logic [7:0]                         bytes_seen, bytes_seen_next;
  logic [7:0]                         running_xor, running_xor_next;
  logic [slxfp_pkg::BANK_W-1:0]       wr_bank;
  logic [7:0]                         seen_inc;
  logic                               frame_ok;

  assign seen_inc = bytes_seen + 8'd1;
  assign frame_ok = (running_xor == rx_byte) &&
                    (frame_length == {1'b0, cfg.expected_length});

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    bytes_seen_next   = bytes_seen;
    running_xor_next  = running_xor;
    wr.en             = 1'b0;
    wr.addr           = {wr_bank, bytes_seen[slxfp_pkg::IDX_W-1:0]};
    wr.data           = rx_byte;
    push              = 1'b0;
    push_cmd.bank     = wr_bank;
    push_cmd.count    = (frame_length > 8'(slxfp_pkg::BUF_DEPTH)) ?
                        slxfp_pkg::RUN_W'(slxfp_pkg::BUF_DEPTH) :
                        frame_length[slxfp_pkg::RUN_W-1:0];
    if (rx_fire) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == cfg.start_code) begin
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          frame_length_next = rx_byte;
          if (rx_byte == 8'd0 || rx_byte > cfg.accept_limit) begin
            phase_next = PH_HUNT;
          end else begin
            bytes_seen_next  = 8'd0;
            running_xor_next = 8'd0;
            phase_next       = PH_DATA;
          end
        end
        PH_DATA: begin
          wr.en            = (bytes_seen < 8'(slxfp_pkg::BUF_DEPTH));
          running_xor_next = running_xor ^ rx_byte;
          bytes_seen_next  = seen_inc;
          if (seen_inc >= frame_length) begin
            phase_next = PH_CSUM;
          end
        end
        PH_CSUM: begin
          push       = frame_ok;
          phase_next = PH_HUNT;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      frame_length <= 8'd0;
      bytes_seen   <= 8'd0;
      running_xor  <= 8'd0;
      wr_bank      <= '0;
    end else begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      bytes_seen   <= bytes_seen_next;
      running_xor  <= running_xor_next;
      if (push) begin
        wr_bank <= wr_bank + 1'b1;
      end
    end
  end

endmodule

@@ design/slxfp_queue.sv @@
// ---------------------------------------------------------------------------
// slxfp_queue: two-entry delivery job queue
// Carries jobs from the front end to the back end in order.
// ---------------------------------------------------------------------------
module slxfp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  slxfp_pkg::cmd_t push_cmd,
  input  logic            pop,
  output slxfp_pkg::cmd_t head,
  output logic            not_empty,
  output logic            full
);

  slxfp_pkg::cmd_t                entries [slxfp_pkg::QUEUE_DEPTH];
  logic [slxfp_pkg::QPTR_W-1:0]   wp, rp;
  logic [slxfp_pkg::QCNT_W-1:0]   count;

  assign head      = entries[rp];
  assign not_empty = (count != '0);
  assign full      = (count == slxfp_pkg::QCNT_W'(slxfp_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/slxfp_back.sv @@
// ---------------------------------------------------------------------------
// slxfp_back: payload store and delivery back end
// Holds the two-bank payload memory and streams each queued job out as a run
// of bytes through a registered read stage and an output register.
// ---------------------------------------------------------------------------
module slxfp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  slxfp_pkg::mem_wr_t            wr,
  input  slxfp_pkg::cmd_t               head,
  input  logic                          not_empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    payload_byte,
  output logic [5:0]                    byte_position,
  output logic                          last_byte
);

  logic [7:0]                        mem [slxfp_pkg::MEM_DEPTH];
  logic [slxfp_pkg::RUN_W-1:0]       rp;
  logic [slxfp_pkg::RUN_W-1:0]       rp_inc;
  logic [slxfp_pkg::MEM_ADDR_W-1:0]  rd_addr;
  logic                              issue, rd_last_next;
  logic                              rd_v, rd_last;
  logic [7:0]                        rd_data;
  logic [5:0]                        rd_pos;
  logic                              out_fire, load_out;

  assign out_fire     = out_valid && !out_stall;
  assign load_out     = rd_v && (!out_valid || out_fire);
  assign issue        = not_empty && (!rd_v || load_out);
  assign rp_inc       = rp + 1'b1;
  assign rd_last_next = (rp_inc == head.count);
  assign pop          = issue && rd_last_next;
  assign rd_addr      = {head.bank, rp[slxfp_pkg::IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[rd_addr];
      rd_pos  <= rp[slxfp_pkg::IDX_W-1:0];
      rd_last <= rd_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      payload_byte  <= rd_data;
      byte_position <= rd_pos;
      last_byte     <= rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp        <= '0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        rp <= '0;
      end else if (issue) begin
        rp <= rp_inc;
      end
      rd_v      <= issue || (rd_v && !load_out);
      out_valid <= load_out || (out_valid && !out_fire);
    end
  end

  // The read counter never runs past the job at the head of the queue.
  a_rp_in_job: assert property (@(posedge clk) disable iff (rst)
    not_empty |-> (rp < head.count))
    else $error("read counter beyond job length");

  // Between jobs the read counter rests at zero.
  a_rp_idle: assert property (@(posedge clk) disable iff (rst)
    !not_empty |-> (rp == '0))
    else $error("read counter not cleared between jobs");

  // A read result that is not moved on must stay put.
  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    (rd_v && !load_out) |=> (rd_v && $stable(rd_data) && $stable(rd_pos)))
    else $error("read stage lost its byte");

  // A job is retired only once its final byte has been read.
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (rd_v && rd_last))
    else $error("job retired without its last byte");

endmodule

@@ verif/frame_payload_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// frame_payload_checker: scoreboard for the start/length/XOR frame parser
// Watches the receive, config and result channels, runs its own copy of the
// parser on every accepted byte and checks delivered payload items in order.
// ---------------------------------------------------------------------------
module frame_payload_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  input  logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] payload_byte,
  input  logic [5:0] byte_position,
  input  logic       last_byte,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         pending,
  output int         mismatches
);

  localparam int MAX_RUN    = 64;

  typedef enum logic [3:0] {
    HUNT         = 4'b0001,
    GET_LENGTH   = 4'b0010,
    GET_PAYLOAD  = 4'b0100,
    GET_CHECKSUM = 4'b1000
  } parse_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic [5:0] pos;
    logic       last;
  } payload_item_t;

  logic [7:0]    start_code;
  logic [6:0]    expected_length;
  logic [7:0]    accept_limit;

  parse_state_t  state;
  logic [7:0]    frame_length;
  logic [7:0]    bytes_seen;
  logic [7:0]    running_xor;
  logic [7:0]    store [slxfp_pkg::BUF_DEPTH];

  payload_item_t expected_payload [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic write_register(input logic [1:0] index, input logic [7:0] data);
    case (index)
      slxfp_pkg::CFG_START_CODE:      start_code      = data;
      slxfp_pkg::CFG_EXPECTED_LENGTH: expected_length = data[6:0];
      slxfp_pkg::CFG_ACCEPT_LIMIT:    accept_limit    = data;
      default: ;
    endcase
  endtask

  // One accepted byte through the parser; a good checksum queues the payload.
  task automatic parse_rx_byte(input logic [7:0] b);
    int            n;
    payload_item_t item;
    case (state)
      HUNT: begin
        if (b == start_code) state = GET_LENGTH;
      end
      GET_LENGTH: begin
        frame_length = b;
        if (b == 8'd0 || b > accept_limit) begin
          state = HUNT;
        end else begin
          bytes_seen  = 8'd0;
          running_xor = 8'd0;
          state       = GET_PAYLOAD;
        end
      end
      GET_PAYLOAD: begin
        if (bytes_seen < slxfp_pkg::BUF_DEPTH) store[bytes_seen[5:0]] = b;
        running_xor = running_xor ^ b;
        bytes_seen  = bytes_seen + 8'd1;
        if (bytes_seen >= frame_length) state = GET_CHECKSUM;
      end
      default: begin
        if (running_xor == b && frame_length == {1'b0, expected_length}) begin
          n = (frame_length > slxfp_pkg::BUF_DEPTH) ? slxfp_pkg::BUF_DEPTH :
                                                       int'(frame_length);
          if (n > MAX_RUN) n = MAX_RUN;
          for (int i = 0; i < n; i++) begin
            item.data = store[6'(i)];
            item.pos  = 6'(i);
            item.last = (i == n - 1);
            expected_payload.push_back(item);
          end
        end
        state = HUNT;
      end
    endcase
  endtask

  always @(posedge clk) begin
    payload_item_t want;
    if (rst) begin
      start_code      = slxfp_pkg::START_CODE_RST;
      expected_length = slxfp_pkg::EXPECTED_LENGTH_RST;
      accept_limit    = slxfp_pkg::ACCEPT_LIMIT_RST;
      state           = HUNT;
      frame_length    = 8'd0;
      bytes_seen      = 8'd0;
      running_xor     = 8'd0;
      expected_payload.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_payload.size() == 0) begin
          report_mismatch($sformatf("unexpected item byte %h pos %0d last %b",
                                    payload_byte, byte_position, last_byte));
        end else begin
          want = expected_payload.pop_front();
          if (payload_byte !== want.data)
            report_mismatch($sformatf("pos %0d: payload_byte %h, want %h",
                                      want.pos, payload_byte, want.data));
          if (byte_position !== want.pos)
            report_mismatch($sformatf("byte_position %0d, want %0d",
                                      byte_position, want.pos));
          if (last_byte !== want.last)
            report_mismatch($sformatf("pos %0d: last_byte %b, want %b",
                                      want.pos, last_byte, want.last));
        end
      end
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (rx_valid && !rx_stall) parse_rx_byte(rx_byte);
    end
    pending <= expected_payload.size();
  end

endmodule

@@ verif/start_length_xor_frame_parser_unit_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// start_length_xor_frame_parser_unit_tb: frame parser testbench
// Feeds framed and broken byte streams under several register settings and
// idling patterns; a checker beside the block predicts and compares payloads.
// ---------------------------------------------------------------------------
module start_length_xor_frame_parser_unit_tb;

  // Index three has no register behind it; writes to it must be ignored.
  localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 400;

  logic       clk;
  logic       rst       = 1'b1;
  logic       rx_valid  = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] payload_byte;
  logic [5:0] byte_position;
  logic       last_byte;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data  = 8'h00;

  int          pending_items;
  int          mismatch_count;
  int unsigned cycle_count;
  int          bytes_sent = 0;

  // Idling knobs, in percent per cycle, changed between phases.
  int          idle_pct   = 0;
  int          stall_pct  = 0;
  bit          hold_go    = 1'b0;

  // The stimulus side keeps its own view of the registers so that it can
  // build frames that the parser will accept or reject on purpose.
  logic [7:0]  cur_start;
  logic [6:0]  cur_exp;
  logic [7:0]  cur_limit;

  start_length_xor_frame_parser_unit uut (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_byte  (payload_byte),
    .byte_position (byte_position),
    .last_byte     (last_byte),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  frame_payload_checker payload_check (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_byte  (payload_byte),
    .byte_position (byte_position),
    .last_byte     (last_byte),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending       (pending_items),
    .mismatches    (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Cycle counter that ends a hung run. It only fires if the stimulus never
  // reaches its verdict, for example when an expected item never shows up.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Result side. Each cycle it stalls with the current probability. Once the
  // pressure phase asks for it, it holds off for a long stretch, counted here,
  // so that both store banks fill up and the block stalls its input.
  initial begin : receiver
    bit held;
    int hold_count;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Offers one byte, after a random number of idle cycles, and returns at the
  // edge where it was accepted. The valid is left high so that the next item
  // can follow back to back; whoever waits on anything else lowers it first.
  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(0, 99) < idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= value;
    do @(posedge clk); while (rx_stall);
    bytes_sent++;
  endtask

  // A complete frame with random payload. With bad_sum set, the checksum is
  // flipped by a nonzero mask so that the frame must be dropped.
  task automatic send_frame(input logic [7:0] len, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'h00;
    send_byte(cur_start);
    send_byte(len);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      sum = sum ^ b;
      send_byte(b);
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  // Lets every expected item come out, then waits SETTLE_CYCLES more so that a
  // frame that should have been dropped has time to show up if it was not.
  task automatic drain();
    rx_valid <= 1'b0;
    do @(posedge clk); while (pending_items != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that back-to-back writes keep it up.
  task automatic write_reg(input logic [1:0] index, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes all three registers while the parser is quiet. The expected length
  // takes its low seven bits, which the stimulus view mirrors.
  task automatic program_regs(input logic [7:0] start, input logic [7:0] exp_data,
                              input logic [7:0] limit, input bit poke_unused);
    rx_valid <= 1'b0;
    write_reg(slxfp_pkg::CFG_START_CODE, start);
    write_reg(slxfp_pkg::CFG_EXPECTED_LENGTH, exp_data);
    write_reg(slxfp_pkg::CFG_ACCEPT_LIMIT, limit);
    if (poke_unused) write_reg(CFG_UNUSED_INDEX, 8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur_start = start;
    cur_exp   = exp_data[6:0];
    cur_limit = limit;
  endtask

  // Mostly well-formed frames of the deliverable length, the rest short frames
  // of random length, bad checksums, rejected length bytes and loose noise.
  task automatic run_random(input int budget);
    int         first;
    int         pick;
    int         top_len;
    logic [7:0] len;
    bit         can_deliver;
    first = bytes_sent;
    can_deliver = (cur_exp != 0) && ({1'b0, cur_exp} <= cur_limit);
    while (bytes_sent - first < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 60 && can_deliver) begin
        send_frame({1'b0, cur_exp}, 1'b0);
      end else if (pick < 72) begin
        top_len = (cur_limit < 16) ? int'(cur_limit) : 16;
        len = 8'($urandom_range(1, top_len));
        send_frame(len, 1'b0);
      end else if (pick < 82 && can_deliver) begin
        send_frame({1'b0, cur_exp}, 1'b1);
      end else if (pick < 90) begin
        send_byte(cur_start);
        if (cur_limit == 8'hFF || $urandom_range(0, 1) == 0) send_byte(8'h00);
        else send_byte(8'($urandom_range(int'(cur_limit) + 1, 255)));
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset register values, with no idling.
    cur_start = slxfp_pkg::START_CODE_RST;
    cur_exp   = slxfp_pkg::EXPECTED_LENGTH_RST;
    cur_limit = slxfp_pkg::ACCEPT_LIMIT_RST;
    idle_pct  = 0;
    stall_pct = 0;

    // A zero length byte, then one just above the accept limit: both go
    // straight back to the hunt.
    send_byte(8'hAA);
    send_byte(8'h00);
    send_byte(8'hAA);
    send_byte(8'h81);
    // A one-byte frame whose checksum equals the start code. The frame is
    // dropped for its length, and the checksum byte must not open a frame;
    // if it did, the following frame would be swallowed.
    send_byte(8'hAA);
    send_byte(8'h01);
    send_byte(8'hAA);
    send_byte(8'hAA);
    send_byte(8'h05);
    // A frame of the reset expected length is delivered.
    send_frame({1'b0, slxfp_pkg::EXPECTED_LENGTH_RST}, 1'b0);
    drain();

    // Start code zero, shortest deliverable frame, widest accept limit.
    program_regs(8'h00, 8'h01, 8'hFF, 1'b1);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'hFF);
    // Same frame with a wrong checksum: dropped.
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h00);
    // Good checksum but a length other than the expected one: dropped.
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h26);
    drain();

    // Random settings with short frames; the sender idles most cycles.
    idle_pct  = 80;
    stall_pct = 0;
    begin
      logic [7:0] exp_pick;
      exp_pick = 8'($urandom_range(1, 8));
      program_regs(8'($urandom_range(0, 255)), exp_pick,
                   8'($urandom_range(int'(exp_pick), 255)), 1'b0);
    end
    run_random(20);
    drain();

    // Extremes: start code all ones, full-store frames, widest limit. The
    // receiver stalls most cycles.
    idle_pct  = 0;
    stall_pct = 80;
    program_regs(8'hFF, 8'd64, 8'hFF, 1'b0);
    run_random(8);
    drain();

    // Expected length written as 0x80, which keeps only zero: nothing can be
    // delivered. The narrowest accept limit still lets length one through.
    idle_pct  = 30;
    stall_pct = 30;
    program_regs(8'h00, 8'h80, 8'h01, 1'b1);
    run_random(10);
    drain();

    // A payload longer than the store: 0xC1 keeps 65 as the expected length,
    // and the accept limit sits right on it. Only 64 bytes come out.
    idle_pct  = 0;
    stall_pct = 0;
    program_regs(8'($urandom_range(0, 255)), 8'hC1, 8'd65, 1'b0);
    send_frame(8'd65, 1'b0);
    send_byte(cur_start);
    send_byte(8'd66);
    drain();

    // Pressure: the receiver holds off for a long stretch while good frames
    // keep coming back to back, so the store banks fill and rx_stall rises.
    program_regs(8'h5A, 8'd6, 8'hFF, 1'b0);
    hold_go = 1'b1;
    repeat (4) send_frame(8'd6, 1'b0);
    drain();

    if (mismatch_count == 0 && pending_items == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/slxfp_pkg.sv
design/slxfp_front.sv
design/slxfp_queue.sv
design/slxfp_back.sv
design/start_length_xor_frame_parser_unit.sv
verif/frame_payload_checker.sv
verif/start_length_xor_frame_parser_unit_tb.sv
